[rtl/cqd_pkg.sv]
// ----------------------------------------------------------------------------
// cqd_pkg
// Shared constants, codes and types of the circular queue with dump.
// ----------------------------------------------------------------------------
package cqd_pkg;

  localparam int DEPTH  = 16;
  localparam int IDX_W  = $clog2(DEPTH);
  localparam int SIZE_W = $clog2(DEPTH + 1);
  localparam int DATA_W = 32;
  localparam int CFG_W  = 5;

  localparam logic [1:0] ACT_ENQUEUE = 2'd0;
  localparam logic [1:0] ACT_DEQUEUE = 2'd1;
  localparam logic [1:0] ACT_DUMP    = 2'd2;
  localparam logic [1:0] ACT_NONE    = 2'd3;

  localparam logic [2:0] ST_ENQUEUED   = 3'd0;
  localparam logic [2:0] ST_DROP_FULL  = 3'd1;
  localparam logic [2:0] ST_DEQUEUED   = 3'd2;
  localparam logic [2:0] ST_DEQ_EMPTY  = 3'd3;
  localparam logic [2:0] ST_DUMP_ITEM  = 3'd4;
  localparam logic [2:0] ST_DUMP_EMPTY = 3'd5;

  typedef enum logic {
    S_IDLE,
    S_DUMP
  } state_t;

  // Control from the sequencer to the result register.
  typedef struct packed {
    logic       imm_vld;     // result without memory data, set on accept
    logic [2:0] imm_status;
    logic       rd_vld;      // memory read data valid this cycle
    logic       rd_dump;     // read belongs to a dump
    logic       rd_last;
  } ctl_t;

endpackage

[rtl/cqd_ram.sv]
// ----------------------------------------------------------------------------
// cqd_ram
// Slot store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module cqd_ram (
  input  logic                            clk,
  input  logic                            we,
  input  logic [cqd_pkg::IDX_W-1:0]       waddr,
  input  logic [cqd_pkg::DATA_W-1:0]      wdata,
  input  logic                            re,
  input  logic [cqd_pkg::IDX_W-1:0]       raddr,
  output logic [cqd_pkg::DATA_W-1:0]      rdata
);

  logic [cqd_pkg::DATA_W-1:0] mem [cqd_pkg::DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[rtl/cqd_ctrl.sv]
// ----------------------------------------------------------------------------
// cqd_ctrl
// Request sequencer: head/tail pointers, ring size and the dump walk.
// ----------------------------------------------------------------------------
module cqd_ctrl (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            start,
  input  logic [1:0]                      action,
  input  logic [cqd_pkg::DATA_W-1:0]      push_value,
  input  logic                            ring_size_we,
  input  logic [cqd_pkg::CFG_W-1:0]       ring_size,
  output logic                            busy,
  output logic                            ram_we,
  output logic [cqd_pkg::IDX_W-1:0]       ram_waddr,
  output logic [cqd_pkg::DATA_W-1:0]      ram_wdata,
  output logic                            ram_re,
  output logic [cqd_pkg::IDX_W-1:0]       ram_raddr,
  output cqd_pkg::ctl_t                   ctl
);

  cqd_pkg::state_t state, state_next;

  logic [cqd_pkg::IDX_W-1:0]  head, head_next;
  logic [cqd_pkg::IDX_W-1:0]  tail, tail_next;
  logic [cqd_pkg::IDX_W-1:0]  ptr, ptr_next;
  logic [cqd_pkg::SIZE_W-1:0] size_q, size_cfg;
  logic                       rd_vld, rd_vld_next;
  logic                       rd_dump, rd_dump_next;
  logic                       rd_last, rd_last_next;
  logic                       accept;
  logic                       empty, full;
  logic [cqd_pkg::IDX_W-1:0]  head_inc, tail_inc, ptr_inc;
  logic                       head_inc_last, ptr_inc_last;

  function automatic logic [cqd_pkg::IDX_W-1:0] wrap_inc(
    input logic [cqd_pkg::IDX_W-1:0]  i,
    input logic [cqd_pkg::SIZE_W-1:0] size
  );
    logic [cqd_pkg::SIZE_W-1:0] n;
    n = cqd_pkg::SIZE_W'(i) + cqd_pkg::SIZE_W'(1);
    return (n >= size) ? '0 : n[cqd_pkg::IDX_W-1:0];
  endfunction

  // Clamp the written size into 1..DEPTH.
  always_comb begin
    priority if (ring_size == '0) begin
      size_cfg = cqd_pkg::SIZE_W'(1);
    end else if (int'(ring_size) > cqd_pkg::DEPTH) begin
      size_cfg = cqd_pkg::SIZE_W'(cqd_pkg::DEPTH);
    end else begin
      size_cfg = cqd_pkg::SIZE_W'(ring_size);
    end
  end

  assign head_inc      = wrap_inc(head, size_q);
  assign tail_inc      = wrap_inc(tail, size_q);
  assign ptr_inc       = wrap_inc(ptr, size_q);
  assign head_inc_last = (head_inc == tail);
  assign ptr_inc_last  = (ptr_inc == tail);
  assign empty         = (head == tail);
  assign full          = (tail_inc == head);
  assign busy          = (state != cqd_pkg::S_IDLE) || rd_vld;
  assign accept        = start && !busy;

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      cqd_pkg::S_IDLE: begin
        if (accept && action == cqd_pkg::ACT_DUMP && !empty && !head_inc_last) begin
          state_next = cqd_pkg::S_DUMP;
        end
      end
      cqd_pkg::S_DUMP: begin
        if (ptr_inc_last) begin
          state_next = cqd_pkg::S_IDLE;
        end
      end
      default: state_next = cqd_pkg::S_IDLE;
    endcase
  end

  // Outputs and datapath next values
  always_comb begin
    head_next      = head;
    tail_next      = tail;
    ptr_next       = ptr;
    rd_vld_next    = 1'b0;
    rd_dump_next   = 1'b0;
    rd_last_next   = 1'b0;
    ram_we         = 1'b0;
    ram_waddr      = tail;
    ram_wdata      = push_value;
    ram_re         = 1'b0;
    ram_raddr      = head;
    ctl.imm_vld    = 1'b0;
    ctl.imm_status = cqd_pkg::ST_ENQUEUED;
    unique case (state)
      cqd_pkg::S_IDLE: begin
        if (accept) begin
          unique case (action)
            cqd_pkg::ACT_ENQUEUE: begin
              ctl.imm_vld = 1'b1;
              if (full) begin
                ctl.imm_status = cqd_pkg::ST_DROP_FULL;
              end else begin
                ram_we    = 1'b1;
                tail_next = tail_inc;
              end
            end
            cqd_pkg::ACT_DEQUEUE: begin
              if (empty) begin
                ctl.imm_vld    = 1'b1;
                ctl.imm_status = cqd_pkg::ST_DEQ_EMPTY;
              end else begin
                ram_re       = 1'b1;
                rd_vld_next  = 1'b1;
                rd_last_next = 1'b1;
                head_next    = head_inc;
              end
            end
            cqd_pkg::ACT_DUMP: begin
              if (empty) begin
                ctl.imm_vld    = 1'b1;
                ctl.imm_status = cqd_pkg::ST_DUMP_EMPTY;
              end else begin
                // read the head entry now, walk the rest from ptr
                ram_re       = 1'b1;
                rd_vld_next  = 1'b1;
                rd_dump_next = 1'b1;
                rd_last_next = head_inc_last;
                ptr_next     = head_inc;
              end
            end
            cqd_pkg::ACT_NONE: begin
            end
            default: begin
            end
          endcase
        end
      end
      cqd_pkg::S_DUMP: begin
        ram_re       = 1'b1;
        ram_raddr    = ptr;
        rd_vld_next  = 1'b1;
        rd_dump_next = 1'b1;
        rd_last_next = ptr_inc_last;
        ptr_next     = ptr_inc;
      end
      default: begin
      end
    endcase
    ctl.rd_vld  = rd_vld;
    ctl.rd_dump = rd_dump;
    ctl.rd_last = rd_last;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= cqd_pkg::S_IDLE;
      head   <= '0;
      tail   <= '0;
      size_q <= cqd_pkg::SIZE_W'(cqd_pkg::DEPTH);
      rd_vld <= 1'b0;
    end else begin
      state  <= state_next;
      rd_vld <= rd_vld_next;
      if (ring_size_we) begin
        size_q <= size_cfg;
        head   <= '0;
        tail   <= '0;
      end else begin
        head <= head_next;
        tail <= tail_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    ptr     <= ptr_next;
    rd_dump <= rd_dump_next;
    rd_last <= rd_last_next;
  end

endmodule

[rtl/circular_queue_with_dump.sv]
// ----------------------------------------------------------------------------
// circular_queue_with_dump
// Ring-buffer FIFO of signed 32-bit words with enqueue, dequeue and dump.
// ----------------------------------------------------------------------------
// Usage:
//   A request (action, push_value) is taken at a rising edge with start high
//   and busy low. Every result appears for one cycle with done high, carrying
//   status, item_value and last; the receiver cannot stall it.
//   Enqueue, or any request on an empty queue: result in the cycle after
//   accept, busy stays low, so one request per cycle.
//   Dequeue: result through the slot store read register, then the result
//   register; busy while the read is pending, so the next request waits.
//   Dump of N stored words: one word per cycle from the single read port,
//   each through the slot store read and result registers, last on the final
//   one; busy until the final read has returned.
//   ring_size is written when ring_size_we is high; the user must do so only
//   while idle, which the block does not enforce. The write clamps the size to
//   1..16 and empties the queue without touching data. Reset empties the queue
//   and sets the ring size to 16; the slot store is not cleared.
// ----------------------------------------------------------------------------
module circular_queue_with_dump (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            start,
  output logic                            busy,
  input  logic [1:0]                      action,
  input  logic signed [31:0]              push_value,
  input  logic                            ring_size_we,
  input  logic [4:0]                      ring_size,
  output logic                            done,
  output logic [2:0]                      status,
  output logic signed [31:0]              item_value,
  output logic                            last
);

  cqd_pkg::ctl_t                  ctl;
  logic                           ram_we, ram_re;
  logic [cqd_pkg::IDX_W-1:0]      ram_waddr, ram_raddr;
  logic [cqd_pkg::DATA_W-1:0]     ram_wdata, ram_rdata;

  cqd_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .action       (action),
    .push_value   (push_value),
    .ring_size_we (ring_size_we),
    .ring_size    (ring_size),
    .busy         (busy),
    .ram_we       (ram_we),
    .ram_waddr    (ram_waddr),
    .ram_wdata    (ram_wdata),
    .ram_re       (ram_re),
    .ram_raddr    (ram_raddr),
    .ctl          (ctl)
  );

  cqd_ram u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Result register: memory data when a read returns, else the status-only result.
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= ctl.imm_vld || ctl.rd_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.rd_vld) begin
      status     <= ctl.rd_dump ? cqd_pkg::ST_DUMP_ITEM : cqd_pkg::ST_DEQUEUED;
      item_value <= ram_rdata;
      last       <= ctl.rd_last;
    end else begin
      status     <= ctl.imm_status;
      item_value <= '0;
      last       <= 1'b1;
    end
  end

  a_no_collide: assert property (@(posedge clk) disable iff (rst)
    !(ctl.imm_vld && ctl.rd_vld))
    else $error("status-only result and read data in the same cycle");

  a_read_busy: assert property (@(posedge clk) disable iff (rst)
    ctl.rd_vld |-> busy)
    else $error("read data pending while ready for a request");

  a_single_last: assert property (@(posedge clk) disable iff (rst)
    (done && (status == cqd_pkg::ST_ENQUEUED || status == cqd_pkg::ST_DROP_FULL ||
              status == cqd_pkg::ST_DEQUEUED || status == cqd_pkg::ST_DEQ_EMPTY ||
              status == cqd_pkg::ST_DUMP_EMPTY)) |-> last)
    else $error("single-result request without last");

  // An empty queue gives a status-only result; a stored word comes from the slot store.
  a_dequeue_timing: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && action == cqd_pkg::ACT_DEQUEUE) |-> ##[1:2] done)
    else $error("dequeue result missing");

endmodule

[tb/sv/circular_queue_with_dump_tb.sv]
// ----------------------------------------------------------------------------
// circular_queue_with_dump_tb
// Self-checking bench for the circular queue with dump. A table of directed
// requests covers the empty and full cases, the smallest ring sizes, clamped
// sizes and the unused action code. Random phases follow, each with its own
// ring size and sender idle rate. A shadow ring predicts each untyped result,
// typed rows carry their own; every result is checked in order.
// ----------------------------------------------------------------------------
module circular_queue_with_dump_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int PLAN_ROWS   = 28;
  localparam int STALL_LIMIT = 500;
  localparam int SETTLE      = 20;
  localparam int MAX_GAP     = 40;

  typedef struct packed {
    logic [2:0]  status;
    logic [31:0] value;
    logic        last;
  } resp_t;

  typedef enum logic {
    ROW_REQ,
    ROW_CFG
  } row_kind_t;

  typedef struct {
    row_kind_t   kind;
    logic [1:0]  act;
    logic [31:0] val;   // push value, or ring size on a config row
    bit          typed; // expectation written out in the row
    logic [2:0]  st;
    logic [31:0] item;
  } plan_row_t;

  logic               clk;
  logic               rst;
  logic               start;
  logic               busy;
  logic [1:0]         action;
  logic signed [31:0] push_value;
  logic               ring_size_we;
  logic [4:0]         ring_size;
  logic               done;
  logic [2:0]         status;
  logic signed [31:0] item_value;
  logic               last;

  circular_queue_with_dump dut (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .action       (action),
    .push_value   (push_value),
    .ring_size_we (ring_size_we),
    .ring_size    (ring_size),
    .done         (done),
    .status       (status),
    .item_value   (item_value),
    .last         (last)
  );

  // Shadow of the ring and its configuration.
  logic [31:0] shadow_slots [cqd_pkg::DEPTH];
  int          shadow_head;
  int          shadow_tail;
  logic [4:0]  shadow_size;

  resp_t       owed_resp [$];
  plan_row_t   plan [PLAN_ROWS];

  int err_count;
  int n_requests;
  int n_results;
  int n_dump_items;
  int n_drops;
  int n_cfg;
  int quiet;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Apply one request to the shadow ring and return the results it causes.
  task automatic ring_step(input logic [1:0] act, input logic [31:0] word,
                           output resp_t outs [$]);
    int s;
    int h;
    int t;
    int i;
    int nx;
    outs = {};
    s = int'(shadow_size);
    if (s < 1) s = 1;
    if (s > cqd_pkg::DEPTH) s = cqd_pkg::DEPTH;
    h = shadow_head % s;
    t = shadow_tail % s;
    case (act)
      cqd_pkg::ACT_ENQUEUE: begin
        if ((t + 1) % s == h) begin
          outs.push_back('{cqd_pkg::ST_DROP_FULL, 32'h0, 1'b1});
        end else begin
          shadow_slots[cqd_pkg::IDX_W'(t)] = word;
          shadow_tail = (t + 1) % s;
          outs.push_back('{cqd_pkg::ST_ENQUEUED, 32'h0, 1'b1});
        end
      end
      cqd_pkg::ACT_DEQUEUE: begin
        if (h == t) begin
          outs.push_back('{cqd_pkg::ST_DEQ_EMPTY, 32'h0, 1'b1});
        end else begin
          outs.push_back('{cqd_pkg::ST_DEQUEUED, shadow_slots[cqd_pkg::IDX_W'(h)],
                           1'b1});
          shadow_head = (h + 1) % s;
        end
      end
      cqd_pkg::ACT_DUMP: begin
        if (h == t) begin
          outs.push_back('{cqd_pkg::ST_DUMP_EMPTY, 32'h0, 1'b1});
        end else begin
          i = h;
          while (i != t) begin
            nx = (i + 1) % s;
            outs.push_back('{cqd_pkg::ST_DUMP_ITEM, shadow_slots[cqd_pkg::IDX_W'(i)],
                             (nx == t)});
            i = nx;
          end
        end
      end
      default: ;
    endcase
  endtask

  // Drive one request and hold it until the block takes it.
  task automatic push_request(input logic [1:0] act, input logic [31:0] word,
                              input bit typed, input logic [2:0] st,
                              input logic [31:0] item);
    resp_t outs [$];
    @(negedge clk);
    start      <= 1'b1;
    action     <= act;
    push_value <= word;
    @(posedge clk);
    while (busy) @(posedge clk);
    ring_step(act, word, outs);
    if (act != cqd_pkg::ACT_NONE) n_requests++;
    if (typed) begin
      owed_resp.push_back('{st, item, 1'b1});
    end else begin
      foreach (outs[k]) owed_resp.push_back(outs[k]);
    end
  endtask

  task automatic hold_off(input int n);
    if (n > 0) begin
      @(negedge clk);
      start      <= 1'b0;
      action     <= 2'($urandom);
      push_value <= $urandom;
      repeat (n - 1) @(negedge clk);
    end
  endtask

  // Write the ring size once the block has gone quiet.
  task automatic set_ring_size(input logic [4:0] sz);
    @(negedge clk);
    start <= 1'b0;
    while (owed_resp.size() != 0 || busy) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    @(negedge clk);
    ring_size_we <= 1'b1;
    ring_size    <= sz;
    @(posedge clk);
    shadow_size = sz;
    shadow_head = 0;
    shadow_tail = 0;
    n_cfg++;
    @(negedge clk);
    ring_size_we <= 1'b0;
  endtask

  task automatic run_phase(input int idle_pct, input int n_items);
    int          sent;
    int          burst_left;
    int          gap;
    int          pick;
    bit          fill_bias;
    bit          calm;
    logic [1:0]  act;
    logic [31:0] word;
    sent       = 0;
    burst_left = 0;
    fill_bias  = 1'b1;
    calm       = 1'b1;
    while (sent < n_items) begin
      // Pick filling or draining bursts at random so the ring reaches full and empty.
      if (burst_left == 0) begin
        burst_left = $urandom_range(8, 24);
        fill_bias  = 1'($urandom_range(0, 1));
        calm       = (idle_pct == 0) || ($urandom_range(0, 3) == 0);
      end
      burst_left--;
      pick = $urandom_range(0, 99);
      if (pick < 4) act = cqd_pkg::ACT_NONE;
      else if (pick < 14) act = cqd_pkg::ACT_DUMP;
      else if (pick < (fill_bias ? 80 : 35)) act = cqd_pkg::ACT_ENQUEUE;
      else act = cqd_pkg::ACT_DEQUEUE;
      word = $urandom;
      if ($urandom_range(0, 7) == 0) begin
        case ($urandom_range(0, 3))
          0:       word = 32'h8000_0000;
          1:       word = 32'h7fff_ffff;
          2:       word = 32'h0000_0000;
          default: word = 32'hffff_ffff;
        endcase
      end
      gap = 0;
      if (!calm) begin
        while (gap < MAX_GAP && $urandom_range(0, 99) < idle_pct) gap++;
      end
      hold_off(gap);
      push_request(act, word, 1'b0, cqd_pkg::ST_ENQUEUED, 32'h0);
      if (act != cqd_pkg::ACT_NONE) sent++;
    end
  endtask

  always @(posedge clk) begin : check_results
    resp_t want;
    if (!rst && done) begin
      n_results++;
      if (status == cqd_pkg::ST_DUMP_ITEM) n_dump_items++;
      if (status == cqd_pkg::ST_DROP_FULL) n_drops++;
      if (owed_resp.size() == 0) begin
        $error("unexpected result: status %0d item_value %0h last %0b",
               status, item_value, last);
        err_count++;
      end else begin
        want = owed_resp.pop_front();
        if (status !== want.status) begin
          $error("status mismatch: expected %0d, got %0d", want.status, status);
          err_count++;
        end
        if (item_value !== want.value) begin
          $error("item_value mismatch: expected %0h, got %0h", want.value, item_value);
          err_count++;
        end
        if (last !== want.last) begin
          $error("last mismatch: expected %0b, got %0b", want.last, last);
          err_count++;
        end
      end
    end
  end

  // Stop a hung run: count cycles with no request taken and no result.
  always @(posedge clk) begin
    if (rst || done || (start && !busy)) begin
      quiet = 0;
    end else begin
      quiet = quiet + 1;
      if (quiet >= STALL_LIMIT) begin
        $display("timeout after %0d quiet cycles, %0d results still owed",
                 quiet, owed_resp.size());
        $display("circular_queue_with_dump_tb: errors");
        $finish;
      end
    end
  end

  initial begin
    rst          = 1'b1;
    start        = 1'b0;
    action       = cqd_pkg::ACT_NONE;
    push_value   = 32'sd0;
    ring_size_we = 1'b0;
    ring_size    = 5'd16;
    err_count    = 0;
    n_requests   = 0;
    n_results    = 0;
    n_dump_items = 0;
    n_drops      = 0;
    n_cfg        = 0;
    quiet        = 0;
    shadow_head  = 0;
    shadow_tail  = 0;
    shadow_size  = 5'd16;
    foreach (shadow_slots[k]) shadow_slots[k] = 32'h0;

    plan = '{
      '{ROW_REQ, cqd_pkg::ACT_DEQUEUE, 32'h0000_0000, 1'b1, cqd_pkg::ST_DEQ_EMPTY,
        32'h0},
      '{ROW_REQ, cqd_pkg::ACT_DUMP,    32'h0000_0000, 1'b1, cqd_pkg::ST_DUMP_EMPTY,
        32'h0},
      '{ROW_REQ, cqd_pkg::ACT_ENQUEUE, 32'h8000_0000, 1'b1, cqd_pkg::ST_ENQUEUED,
        32'h0},
      '{ROW_REQ, cqd_pkg::ACT_ENQUEUE, 32'h7fff_ffff, 1'b1, cqd_pkg::ST_ENQUEUED,
        32'h0},
      '{ROW_REQ, cqd_pkg::ACT_ENQUEUE, 32'h0000_0000, 1'b1, cqd_pkg::ST_ENQUEUED,
        32'h0},
      '{ROW_REQ, cqd_pkg::ACT_ENQUEUE, 32'hffff_ffff, 1'b1, cqd_pkg::ST_ENQUEUED,
        32'h0},
      '{ROW_REQ, cqd_pkg::ACT_NONE,    32'h5a5a_5a5a, 1'b0, cqd_pkg::ST_ENQUEUED,
        32'h0},
      '{ROW_REQ, cqd_pkg::ACT_DUMP,    32'h0000_0000, 1'b0, cqd_pkg::ST_ENQUEUED,
        32'h0},
      '{ROW_REQ, cqd_pkg::ACT_DEQUEUE, 32'h0000_0000, 1'b1, cqd_pkg::ST_DEQUEUED,
        32'h8000_0000},
      '{ROW_REQ, cqd_pkg::ACT_DEQUEUE, 32'h0000_0000, 1'b1, cqd_pkg::ST_DEQUEUED,
        32'h7fff_ffff},
      // a size write empties the ring; two slots hold one word
      '{ROW_CFG, cqd_pkg::ACT_NONE,    32'd2,         1'b0, cqd_pkg::ST_ENQUEUED,
        32'h0},
      '{ROW_REQ, cqd_pkg::ACT_DEQUEUE, 32'h0000_0000, 1'b1, cqd_pkg::ST_DEQ_EMPTY,
        32'h0},
      '{ROW_REQ, cqd_pkg::ACT_ENQUEUE, 32'h1234_5678, 1'b1, cqd_pkg::ST_ENQUEUED,
        32'h0},
      '{ROW_REQ, cqd_pkg::ACT_ENQUEUE, 32'h0000_0000, 1'b1, cqd_pkg::ST_DROP_FULL,
        32'h0},
      '{ROW_REQ, cqd_pkg::ACT_DUMP,    32'h0000_0000, 1'b0, cqd_pkg::ST_ENQUEUED,
        32'h0},
      '{ROW_REQ, cqd_pkg::ACT_DEQUEUE, 32'h0000_0000, 1'b1, cqd_pkg::ST_DEQUEUED,
        32'h1234_5678},
      // one slot: always full and empty at once
      '{ROW_CFG, cqd_pkg::ACT_NONE,    32'd1,         1'b0, cqd_pkg::ST_ENQUEUED,
        32'h0},
      '{ROW_REQ, cqd_pkg::ACT_ENQUEUE, 32'habcd_ef01, 1'b1, cqd_pkg::ST_DROP_FULL,
        32'h0},
      '{ROW_REQ, cqd_pkg::ACT_DEQUEUE, 32'h0000_0000, 1'b1, cqd_pkg::ST_DEQ_EMPTY,
        32'h0},
      '{ROW_REQ, cqd_pkg::ACT_DUMP,    32'h0000_0000, 1'b1, cqd_pkg::ST_DUMP_EMPTY,
        32'h0},
      // zero clamps up to one slot
      '{ROW_CFG, cqd_pkg::ACT_NONE,    32'd0,         1'b0, cqd_pkg::ST_ENQUEUED,
        32'h0},
      '{ROW_REQ, cqd_pkg::ACT_ENQUEUE, 32'h0000_0001, 1'b1, cqd_pkg::ST_DROP_FULL,
        32'h0},
      '{ROW_REQ, cqd_pkg::ACT_DEQUEUE, 32'h0000_0000, 1'b1, cqd_pkg::ST_DEQ_EMPTY,
        32'h0},
      // above the store depth clamps down to the full ring
      '{ROW_CFG, cqd_pkg::ACT_NONE,    32'd31,        1'b0, cqd_pkg::ST_ENQUEUED,
        32'h0},
      '{ROW_REQ, cqd_pkg::ACT_ENQUEUE, 32'h0f0f_0f0f, 1'b1, cqd_pkg::ST_ENQUEUED,
        32'h0},
      '{ROW_REQ, cqd_pkg::ACT_DUMP,    32'h0000_0000, 1'b0, cqd_pkg::ST_ENQUEUED,
        32'h0},
      '{ROW_REQ, cqd_pkg::ACT_DEQUEUE, 32'h0000_0000, 1'b1, cqd_pkg::ST_DEQUEUED,
        32'h0f0f_0f0f},
      '{ROW_REQ, cqd_pkg::ACT_DEQUEUE, 32'h0000_0000, 1'b1, cqd_pkg::ST_DEQ_EMPTY,
        32'h0}
    };

    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (plan[r]) begin
      if (plan[r].kind == ROW_CFG) begin
        set_ring_size(plan[r].val[4:0]);
      end else begin
        push_request(plan[r].act, plan[r].val, plan[r].typed, plan[r].st, plan[r].item);
      end
    end

    set_ring_size(5'd16);
    run_phase(0, 44);
    set_ring_size(5'($urandom_range(3, 15)));
    run_phase(82, 44);
    set_ring_size(5'd2);
    run_phase(0, 44);
    set_ring_size(5'($urandom_range(17, 31)));
    run_phase(25, 46);

    @(negedge clk);
    start <= 1'b0;
    while (owed_resp.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);

    $display("covered %0d requests, %0d results (%0d dumped words, %0d full drops)",
             n_requests, n_results, n_dump_items, n_drops);
    $display("over %0d ring size writes, with clamped sizes and sender idle phases",
             n_cfg);
    if (err_count == 0) begin
      $display("circular_queue_with_dump_tb: clean");
    end else begin
      $display("circular_queue_with_dump_tb: errors");
    end
    $finish;
  end

endmodule

[circular_queue_with_dump.f]
rtl/cqd_pkg.sv
rtl/cqd_ram.sv
rtl/cqd_ctrl.sv
rtl/circular_queue_with_dump.sv
tb/sv/circular_queue_with_dump_tb.sv
